// ===== rtl/matrix_multiply_top_assert.svh =====
// Assertion helpers for the matrix multiply block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MM_ASSERT_NOW(label, ante, cons, msg)
`define MM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  // defaults for the top-level parameters
  localparam int MAX_DIM_DEF    = 8;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // config port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A = 3'd0,
    CFG_COLS_A = 3'd1,
    CFG_ROWS_B = 3'd2,
    CFG_COLS_B = 3'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_ADDR = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

endpackage

// ===== rtl/matrix_multiply_top.sv =====
`timescale 1ns / 1ps

`include "matrix_multiply_top_assert.svh"

// Fixed-point matrix multiply, C = A x B, with one shared multiply-accumulate.
// Program rows_a, cols_a, rows_b, cols_b (index 0..3; 0 acts as 1, values above
// MAX_DIM act as MAX_DIM) while the block is idle; any register write restarts
// loading. Then send all of A row-major followed by all of B row-major, one
// signed Q(FRAC_BITS) element per item, one item per cycle. The item that
// carries the last element of B starts the run: C comes out row-major,
// rows_a x cols_b items, the final one marked with last. If cols_a differs from
// rows_b a single item with dim_error (and last) set replaces C. Each sum
// term is the full product floored by FRAC_BITS; sums are exact and clipped
// to the signed ELEM_WIDTH range, flagged by saturated.
// Datapath: every term of a result goes through the store read register, the
// multiplier register and the accumulator in turn, using the one multiplier,
// so the block takes no new term before the last one is through. Input is
// stalled for the whole run.
module matrix_multiply_top #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS  = mm_pkg::FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]     cfg_data_i,
  // element input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ELEM_WIDTH-1:0] element_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [ELEM_WIDTH-1:0] product_o,
  output logic                         dim_error_o,
  output logic                         saturated_o,
  output logic                         last_o
);

  localparam int CFG_W  = mm_pkg::CFG_W;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);              // holds 1..MAX_DIM
  localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W  = 2 * DIM_W + 1;                    // holds na + nb
  localparam int PW     = 2 * ELEM_WIDTH;                   // full product
  localparam int SW     = PW - FRAC_BITS;                   // floored product
  localparam int AW     = SW + DIM_W;                       // exact sum

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // config registers
  logic [CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CFG_W'(1);
      cols_a_q <= CFG_W'(1);
      rows_b_q <= CFG_W'(1);
      cols_b_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (mm_pkg::cfg_idx_e'(cfg_index_i))
        mm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
        mm_pkg::CFG_COLS_A: cols_a_q <= cfg_data_i;
        mm_pkg::CFG_ROWS_B: rows_b_q <= cfg_data_i;
        mm_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a write to a listed register restarts loading while in ST_LOAD
  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_index_i == mm_pkg::CFG_ROWS_A ||
                                cfg_index_i == mm_pkg::CFG_COLS_A ||
                                cfg_index_i == mm_pkg::CFG_ROWS_B ||
                                cfg_index_i == mm_pkg::CFG_COLS_B);

  logic [DIM_W-1:0] ra, ca, rb, cb;
  logic [TOT_W-1:0] na, nb, total;

  assign ra    = eff_dim(rows_a_q);
  assign ca    = eff_dim(cols_a_q);
  assign rb    = eff_dim(rows_b_q);
  assign cb    = eff_dim(cols_b_q);
  assign na    = TOT_W'(ra) * TOT_W'(ca);
  assign nb    = TOT_W'(rb) * TOT_W'(cb);
  assign total = na + nb;

  // ---------------------------------------------------------------------------
  // sequencer state
  mm_pkg::state_e state_q, state_d;
  logic [TOT_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [PW-1:0] prod_q;
  logic signed [ELEM_WIDTH-1:0] a_rd_q, b_rd_q;
  logic signed [ELEM_WIDTH-1:0] out_prod_q, out_prod_d;
  logic out_err_q, out_err_d, out_sat_q, out_sat_d, out_last_q, out_last_d;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // ---------------------------------------------------------------------------
  // element stores
  logic signed [ELEM_WIDTH-1:0] left_mem  [DEPTH];
  logic signed [ELEM_WIDTH-1:0] right_mem [DEPTH];

  logic             load_left;
  logic [TOT_W-1:0] right_lin, a_lin, b_lin;
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

  assign load_left = (load_cnt_q < na);
  assign right_lin = load_cnt_q - na;
  assign wr_addr   = load_left ? load_cnt_q[ADDR_W-1:0] : right_lin[ADDR_W-1:0];
  assign a_lin     = TOT_W'(i_q) * TOT_W'(ca) + TOT_W'(k_q);
  assign b_lin     = TOT_W'(k_q) * TOT_W'(cb) + TOT_W'(j_q);
  assign a_addr    = a_lin[ADDR_W-1:0];
  assign b_addr    = b_lin[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc && load_left) begin
      left_mem[wr_addr] <= element_i;
    end
    a_rd_q <= left_mem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !load_left) begin
      right_mem[wr_addr] <= element_i;
    end
    b_rd_q <= right_mem[b_addr];
  end

  // ---------------------------------------------------------------------------
  // shared MAC datapath
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(a_rd_q) * PW'(b_rd_q);
  end

  logic signed [SW-1:0] prod_sh;
  logic signed [AW-1:0] sum;
  logic                 sum_fits;

  assign prod_sh  = SW'(prod_q >>> FRAC_BITS);   // arithmetic shift = floor
  assign sum      = acc_q + AW'(prod_sh);
  assign sum_fits = (sum[AW-1:ELEM_WIDTH-1] == '0) || (sum[AW-1:ELEM_WIDTH-1] == '1);

  logic k_last, j_last, i_last;
  assign k_last = (DIM_W'(k_q) + DIM_W'(1)) == ca;
  assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == cb;
  assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == ra;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    acc_d      = acc_q;
    out_prod_d = out_prod_q;
    out_err_d  = out_err_q;
    out_sat_d  = out_sat_q;
    out_last_d = out_last_q;

    unique case (state_q)
      mm_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (load_cnt_q + TOT_W'(1) == total) begin
            load_cnt_d = '0;
            if (ca != rb) begin
              out_prod_d = '0;
              out_err_d  = 1'b1;
              out_sat_d  = 1'b0;
              out_last_d = 1'b1;
              state_d    = mm_pkg::ST_OUT;
            end else begin
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              acc_d   = '0;
              state_d = mm_pkg::ST_ADDR;
            end
          end else begin
            load_cnt_d = load_cnt_q + TOT_W'(1);
          end
        end
        if (cfg_hit) begin
          load_cnt_d = '0;
        end
      end
      mm_pkg::ST_ADDR: state_d = mm_pkg::ST_MUL;   // store read registers load
      mm_pkg::ST_MUL:  state_d = mm_pkg::ST_ACC;   // product register loads
      mm_pkg::ST_ACC: begin
        acc_d = sum;
        if (k_last) begin
          out_err_d  = 1'b0;
          out_sat_d  = !sum_fits;
          out_last_d = i_last && j_last;
          if (sum_fits) begin
            out_prod_d = sum[ELEM_WIDTH-1:0];
          end else if (sum[AW-1]) begin
            out_prod_d = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
          end else begin
            out_prod_d = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
          end
          state_d = mm_pkg::ST_OUT;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = mm_pkg::ST_ADDR;
        end
      end
      mm_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (out_last_q) begin
            state_d = mm_pkg::ST_LOAD;
          end else begin
            k_d   = '0;
            acc_d = '0;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + CNT_W'(1);
            end else begin
              j_d = j_q + CNT_W'(1);
            end
            state_d = mm_pkg::ST_ADDR;
          end
        end
      end
      default: state_d = mm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mm_pkg::ST_LOAD;
      load_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_prod_q <= out_prod_d;
    out_err_q  <= out_err_d;
    out_sat_q  <= out_sat_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (state_q != mm_pkg::ST_LOAD);
  assign out_valid_o = (state_q == mm_pkg::ST_OUT);
  assign product_o   = out_prod_q;
  assign dim_error_o = out_err_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  `MM_ASSERT_NOW(a_no_load_during_run, out_valid_o, in_stall_o,
                 "item accepted while results pending")
  `MM_ASSERT_NOW(a_err_item_shape, out_valid_o && dim_error_o,
                 last_o && !saturated_o && product_o == '0,
                 "malformed dimension error item")
  `MM_ASSERT_NEXT(a_idle_after_last, out_acc && last_o, !in_stall_o,
                  "block not ready after final result")
  `MM_ASSERT_NOW(a_load_cnt_range, state_q == mm_pkg::ST_LOAD, load_cnt_q < total,
                 "load count beyond matrix sizes")

endmodule
